>>> src/gsci_pkg.sv
// gas sensor curve interpolator: shared types, constants and helpers
// used by the top level, the serial divider and the port checker
package gsci_pkg;

  localparam int CURVE_POINTS = 10;
  localparam int CIDX_W       = $clog2(CURVE_POINTS);
  localparam logic [9:0] ADC_FULL_SCALE = 10'd1023;
  localparam int CAL_LEN      = 10;

  localparam int DIV_W        = 32;
  localparam int DIV_REM_W    = 24;
  // two quotient bits per cycle
  localparam int DIV_STEPS    = DIV_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MODE = 1'd1;
  localparam logic [15:0] LOAD_RES_RESET = 16'd1000;

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_CAL     = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OUT_OF_CURVE = 3'd1,
    ST_INVALID      = 3'd2,
    ST_ACCEPTED     = 3'd3,
    ST_CAL_DONE     = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  sample;
    logic [3:0]  point_index;
    logic [23:0] point_ratio;
    logic [31:0] point_density;
  } gsci_in_t;

  typedef struct packed {
    logic [31:0] density;
    logic [15:0] sensor_resistance;
    logic [23:0] ratio;
    status_t     status;
  } gsci_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // floor(x / 10) by reciprocal, exact for every 14-bit x
  function automatic logic [10:0] div10(input logic [13:0] x);
    logic [29:0] p;
    p = x * 16'd52429;
    return p[29:19];
  endfunction

endpackage

>>> src/gsci_div.sv
// serial restoring divider, two quotient bits per cycle
// depends on gsci_pkg for widths and request/response types
module gsci_div import gsci_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_REM_W-1:0] dsr;
  logic [DIV_W-1:0]     quo;
  logic [DIV_REM_W:0]   t1;
  logic [DIV_REM_W:0]   t2;

  function automatic logic [DIV_REM_W:0] rstep(input logic [DIV_REM_W-1:0] r,
                                               input logic b,
                                               input logic [DIV_REM_W-1:0] d);
    logic [DIV_REM_W:0] s;
    logic [DIV_REM_W:0] t;
    s = {r, b};
    t = s - {1'b0, d};
    if (s >= {1'b0, d}) begin
      return {1'b1, t[DIV_REM_W-1:0]};
    end
    return {1'b0, s[DIV_REM_W-1:0]};
  endfunction

  always_comb begin
    t1 = rstep(rem, quo[DIV_W-1], dsr);
    t2 = rstep(t1[DIV_REM_W-1:0], quo[DIV_W-2], dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (run) begin
      rem <= t2[DIV_REM_W-1:0];
      quo <= {quo[DIV_W-3:0], t1[DIV_REM_W], t2[DIV_REM_W]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> src/gas_sensor_curve_interpolator.sv
// gas sensor curve interpolator top level: control, calibration, curve store
// depends on gsci_pkg and gsci_div
//
// Input words arrive on in_valid/in_stall/in_word, results leave on
// out_valid/out_stall/out_word, one result word per input word, in order.
// Registers are written through cfg_wen/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// A measure word runs three divisions on the shared serial divider (sensor
// resistance, reference resistance, ratio), a scan over the curve points
// one per cycle, and a fourth division for the interpolation. A measurement
// ends early on a zero sample, a zero reference reading, a zero reference
// resistance or no matching segment. The input is free again the cycle
// after a result is written.
// One word is in work at a time; in_stall is high while it is. A finished
// result sits in the output register while the receiver stalls, and the next
// input word is taken meanwhile; its result waits until the register frees.
// Reset clears the sums, counters and reference reading, sets the load
// resistance to 1000 ohms and calibration to ten samples. Curve points hold
// no value until loaded.
module gas_sensor_curve_interpolator import gsci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gsci_in_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsci_out_t            out_word,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MEAS, S_RS_DIV, S_R0_DIV, S_RATIO_DIV, S_SEARCH,
    S_INT, S_INT_DIV, S_CAL_GRP, S_CAL_OUT, S_DONE
  } state_t;

  localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(CURVE_POINTS - 1);

  state_t      state;
  logic [15:0] load_res;
  logic        cal_mode;
  logic [9:0]  ref_reading;
  logic [13:0] group_sum;
  logic [13:0] outer_sum;
  logic [3:0]  sample_count;
  logic [3:0]  group_count;

  logic [23:0] curve_ratio [CURVE_POINTS];
  logic [31:0] curve_density [CURVE_POINTS];

  logic [9:0]        sample_r;
  logic [15:0]       rs_r;
  logic [23:0]       ratio_r;
  logic [31:0]       dens_r;
  status_t           status_r;
  logic [CIDX_W-1:0] scan_idx;
  logic [23:0]       prev_ratio;
  logic [31:0]       prev_dens;
  logic [23:0]       span;
  logic [23:0]       dx;
  logic [31:0]       dd;
  logic [31:0]       seg_d0;
  logic              seg_neg;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [15:0] q_sat16;
  logic [23:0] cur_ratio;
  logic [31:0] cur_dens;
  logic [13:0] gsum_add;
  logic [3:0]  cnt_add;
  logic [10:0] gavg;
  logic [10:0] oavg;
  logic [13:0] outer_add;
  logic [3:0]  gcnt_add;
  logic [55:0] int_prod;

  function automatic logic [25:0] res_num(input logic [15:0] l, input logic [9:0] a);
    logic [9:0] diff;
    diff = (a >= ADC_FULL_SCALE) ? 10'd0 : ADC_FULL_SCALE - a;
    return l * diff;
  endfunction

  gsci_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall  = (state != S_IDLE);
  assign q_sat16   = (|div_rsp.quotient[31:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
  assign cur_ratio = curve_ratio[scan_idx];
  assign cur_dens  = curve_density[scan_idx];
  assign gsum_add  = group_sum + 14'(in_word.sample);
  assign cnt_add   = sample_count + 4'd1;
  assign gavg      = div10(group_sum);
  assign oavg      = div10(outer_sum);
  assign outer_add = outer_sum + 14'(gavg);
  assign gcnt_add  = group_count + 4'd1;
  assign int_prod  = dd * dx;

  always_comb begin
    div_req = '0;
    unique case (state)
      S_MEAS: begin
        div_req.start    = (sample_r != 10'd0);
        div_req.dividend = {6'd0, res_num(load_res, sample_r)};
        div_req.divisor  = {14'd0, sample_r};
      end
      S_RS_DIV: begin
        div_req.start    = div_rsp.done && (ref_reading != 10'd0);
        div_req.dividend = {6'd0, res_num(load_res, ref_reading)};
        div_req.divisor  = {14'd0, ref_reading};
      end
      S_R0_DIV: begin
        div_req.start    = div_rsp.done && (q_sat16 != 16'd0);
        div_req.dividend = {rs_r, 16'd0};
        div_req.divisor  = {8'd0, q_sat16};
      end
      S_INT: begin
        div_req.start    = 1'b1;
        div_req.rem_init = int_prod[55:32];
        div_req.dividend = int_prod[31:0];
        div_req.divisor  = span;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      load_res     <= LOAD_RES_RESET;
      cal_mode     <= 1'b0;
      ref_reading  <= '0;
      group_sum    <= '0;
      outer_sum    <= '0;
      sample_count <= '0;
      group_count  <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_LOAD_RES: load_res <= cfg_data;
          REG_CAL_MODE: cal_mode <= cfg_data[0];
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_word.sample;
            rs_r     <= '0;
            ratio_r  <= '0;
            dens_r   <= '0;
            status_r <= ST_ACCEPTED;
            unique case (in_word.cmd)
              CMD_MEASURE: state <= S_MEAS;
              CMD_CAL: begin
                group_sum <= gsum_add;
                if (cnt_add < 4'(CAL_LEN)) begin
                  sample_count <= cnt_add;
                  state        <= S_DONE;
                end else begin
                  state <= S_CAL_GRP;
                end
              end
              CMD_LOAD: begin
                if (int'(in_word.point_index) < CURVE_POINTS) begin
                  curve_ratio[CIDX_W'(in_word.point_index)]   <= in_word.point_ratio;
                  curve_density[CIDX_W'(in_word.point_index)] <= in_word.point_density;
                end
                state <= S_DONE;
              end
              CMD_RSVD: state <= S_DONE;
            endcase
          end
        end
        S_CAL_GRP: begin
          group_sum    <= '0;
          sample_count <= '0;
          if (!cal_mode) begin
            ref_reading <= gavg[9:0];
            outer_sum   <= '0;
            group_count <= '0;
            status_r    <= ST_CAL_DONE;
            state       <= S_DONE;
          end else if (gcnt_add < 4'(CAL_LEN)) begin
            outer_sum   <= outer_add;
            group_count <= gcnt_add;
            state       <= S_DONE;
          end else begin
            outer_sum <= outer_add;
            state     <= S_CAL_OUT;
          end
        end
        S_CAL_OUT: begin
          ref_reading <= oavg[9:0];
          outer_sum   <= '0;
          group_count <= '0;
          status_r    <= ST_CAL_DONE;
          state       <= S_DONE;
        end
        S_MEAS: begin
          if (sample_r == 10'd0) begin
            status_r <= ST_INVALID;
            state    <= S_DONE;
          end else begin
            state <= S_RS_DIV;
          end
        end
        S_RS_DIV: begin
          if (div_rsp.done) begin
            rs_r <= q_sat16;
            if (ref_reading == 10'd0) begin
              status_r <= ST_INVALID;
              state    <= S_DONE;
            end else begin
              state <= S_R0_DIV;
            end
          end
        end
        S_R0_DIV: begin
          if (div_rsp.done) begin
            if (q_sat16 == 16'd0) begin
              status_r <= ST_INVALID;
              state    <= S_DONE;
            end else begin
              state <= S_RATIO_DIV;
            end
          end
        end
        S_RATIO_DIV: begin
          if (div_rsp.done) begin
            ratio_r  <= (|div_rsp.quotient[31:24]) ? 24'hFFFFFF : div_rsp.quotient[23:0];
            scan_idx <= LAST_IDX;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (scan_idx == LAST_IDX) begin
            prev_ratio <= cur_ratio;
            prev_dens  <= cur_dens;
            scan_idx   <= scan_idx - 1'b1;
          end else if (prev_ratio <= ratio_r && ratio_r < cur_ratio) begin
            span    <= cur_ratio - prev_ratio;
            dx      <= ratio_r - prev_ratio;
            seg_d0  <= prev_dens;
            seg_neg <= (cur_dens < prev_dens);
            dd      <= (cur_dens < prev_dens) ? prev_dens - cur_dens : cur_dens - prev_dens;
            state   <= S_INT;
          end else if (scan_idx == '0) begin
            status_r <= ST_OUT_OF_CURVE;
            state    <= S_DONE;
          end else begin
            prev_ratio <= cur_ratio;
            prev_dens  <= cur_dens;
            scan_idx   <= scan_idx - 1'b1;
          end
        end
        S_INT: state <= S_INT_DIV;
        S_INT_DIV: begin
          if (div_rsp.done) begin
            dens_r   <= seg_neg ? seg_d0 - div_rsp.quotient : seg_d0 + div_rsp.quotient;
            status_r <= ST_OK;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_word.density           <= dens_r;
            out_word.sensor_resistance <= rs_r;
            out_word.ratio             <= ratio_r;
            out_word.status            <= status_r;
            out_valid                  <= 1'b1;
            state                      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> src/gsci_checker.sv
// port-level checker for the gas sensor curve interpolator and its bind
// depends on gsci_pkg for the word types and status codes
module gsci_checker import gsci_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input gsci_in_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input gsci_out_t out_word
);

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_density_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_OK |-> out_word.density == 32'd0)
    else $error("density set without ok status");

  a_non_measure_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_ACCEPTED || out_word.status == ST_CAL_DONE)
    |-> out_word.sensor_resistance == 16'd0 && out_word.ratio == 24'd0)
    else $error("non-measure result carries measurement fields");

  a_invalid_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == ST_INVALID |-> out_word.ratio == 24'd0)
    else $error("ratio reported with invalid divisor");

endmodule

bind gas_sensor_curve_interpolator gsci_checker u_gsci_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
